[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the line-fit block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, held off while reset is low.
`define LSLF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: check failed");

// Same, with a caller message.
`define LSLF_ASSERT_MSG(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

`endif

[rtl/core/lslf_pkg.sv]
// Shared constants, micro-op codes and controller/datapath link types
// for the least-squares line fit. Depends on nothing.
package lslf_pkg;

    localparam int XW         = 16;
    localparam int MAX_POINTS = 4096;
    localparam int CNTW       = 13;
    localparam int FRAC_BITS  = 8;
    localparam int SUMW       = 28;
    localparam int SQW        = 44;
    localparam int TW         = 72;   // signed scratch for partial differences
    localparam int DW         = 56;   // dx, dy, |dxy|
    localparam int MA_W       = 112;  // multiplier operand a
    localparam int MB_W       = 64;   // multiplier operand b
    localparam int MP_W       = MA_W + MB_W;
    localparam int PRW        = 128;  // product of dx, dx*n or dx^2 with n
    localparam int NUM_W      = 160;  // divider dividend
    localparam int DEN_W      = 140;  // divider divisor and remainder
    localparam int QF         = 16;   // quotient fraction bits
    localparam int QW         = 32;
    localparam int STEPW      = 5;

    localparam logic [QW-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] LIM_NEG = 32'h8000_0000;
    localparam logic [QW-1:0] LIM_U   = 32'hFFFF_FFFF;
    localparam logic [QW-1:0] LIM_R2  = 32'h0001_0000;

    typedef enum logic [4:0] {
        OP_MUL_N_SXX,
        OP_MUL_SX_SX,
        OP_MUL_N_SYY,
        OP_MUL_SY_SY,
        OP_MUL_N_SXY,
        OP_MUL_SX_SY,
        OP_CHECK,
        OP_MUL_SY_SXX,
        OP_MUL_SX_SXY,
        OP_MUL_DXY_DXY,
        OP_MUL_DX_DY,
        OP_DIV_SLOPE,
        OP_DIV_ICPT,
        OP_DIV_R2,
        OP_MUL_DX_N,
        OP_MUL_T_N,
        OP_DIV_RES,
        OP_MUL_DX_DX,
        OP_DIV_SVAR,
        OP_MUL_DX2_N,
        OP_MUL_E_SXX,
        OP_DIV_IVAR,
        OP_END
    } op_t;

    typedef struct packed {
        logic acc;
        logic start;
        op_t  op;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic degen;
        logic out_free;
    } status_t;

    // Fit program: one micro-op per step.
    function automatic op_t prog(input logic [STEPW-1:0] step);
        op_t op;
        unique case (step)
            5'd0:    op = OP_MUL_N_SXX;
            5'd1:    op = OP_MUL_SX_SX;
            5'd2:    op = OP_MUL_N_SYY;
            5'd3:    op = OP_MUL_SY_SY;
            5'd4:    op = OP_MUL_N_SXY;
            5'd5:    op = OP_MUL_SX_SY;
            5'd6:    op = OP_CHECK;
            5'd7:    op = OP_MUL_SY_SXX;
            5'd8:    op = OP_MUL_SX_SXY;
            5'd9:    op = OP_MUL_DXY_DXY;
            5'd10:   op = OP_MUL_DX_DY;
            5'd11:   op = OP_DIV_SLOPE;
            5'd12:   op = OP_DIV_ICPT;
            5'd13:   op = OP_DIV_R2;
            5'd14:   op = OP_MUL_DX_N;
            5'd15:   op = OP_MUL_T_N;
            5'd16:   op = OP_DIV_RES;
            5'd17:   op = OP_MUL_DX_DX;
            5'd18:   op = OP_DIV_SVAR;
            5'd19:   op = OP_MUL_DX2_N;
            5'd20:   op = OP_MUL_E_SXX;
            5'd21:   op = OP_DIV_IVAR;
            default: op = OP_END;
        endcase
        return op;
    endfunction

    function automatic logic is_div(input op_t op);
        return (op == OP_DIV_SLOPE) || (op == OP_DIV_ICPT) || (op == OP_DIV_R2) ||
               (op == OP_DIV_RES) || (op == OP_DIV_SVAR) || (op == OP_DIV_IVAR);
    endfunction

endpackage

[rtl/core/least_squares_line_fit.sv]
// Least-squares line fit over a stream of signed Q8.8 (x, y) pairs.
// Throughput: one pair per cycle while accumulating. A pair marked last starts
// the fit: 15 shift-add multiplier passes, 6 divider passes, a check step and an
// end step, then a load step that raises m_valid; a degenerate set skips to the load
// after the check step, and the load waits while an older result is still unaccepted.
// Reset (aresetn, synchronous, active low) clears sums, count and valids.
module least_squares_line_fit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_x_sample,
    input  logic signed [15:0]  s_y_sample,
    input  logic                s_last_point,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_slope,
    output logic signed [31:0]  m_intercept,
    output logic [16:0]         m_r_squared,
    output logic [31:0]         m_residual_var,
    output logic [31:0]         m_slope_var,
    output logic [31:0]         m_intercept_var,
    output logic [12:0]         m_point_total,
    output logic                m_degenerate
);
    // Controller and datapath talk only through these two bundles:
    // cmd carries accumulate, start-op and load-result strobes,
    // status returns unit done, degenerate set and output-register free.
    lslf_pkg::cmd_t    cmd;
    lslf_pkg::status_t status;

    // Sequencer: accept a transaction per cycle in accumulate mode, run
    // the fit program on the last pair, then hold until the result
    // register is free and drop the sums for the next data set.
    lslf_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_point (s_last_point),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath: sums, shared multiplier and divider, and the output
    // register that lets a new data set stream in while a result waits.
    lslf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .x_sample        (s_x_sample),
        .y_sample        (s_y_sample),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_slope         (m_slope),
        .m_intercept     (m_intercept),
        .m_r_squared     (m_r_squared),
        .m_residual_var  (m_residual_var),
        .m_slope_var     (m_slope_var),
        .m_intercept_var (m_intercept_var),
        .m_point_total   (m_point_total),
        .m_degenerate    (m_degenerate)
    );
endmodule

[rtl/core/lslf_mul.sv]
// Shift-add multiplier, one bit of operand b per cycle.
// Depends on lslf_pkg for operand widths.
module lslf_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lslf_pkg::MA_W-1:0]   a,
    input  logic [lslf_pkg::MB_W-1:0]   b,
    output logic [lslf_pkg::MP_W-1:0]   p,
    output logic                        done
);
    localparam int MP_W = lslf_pkg::MP_W;
    localparam int MB_W = lslf_pkg::MB_W;
    localparam int CW   = $clog2(MB_W);

    logic [MP_W-1:0] p_reg, a_reg;
    logic [MB_W-1:0] b_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg, done_reg;
    logic            last;

    assign last = (cnt_reg == CW'(MB_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            p_reg <= '0;
            a_reg <= MP_W'(a);
            b_reg <= b;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                p_reg <= p_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign p    = p_reg;
    assign done = done_reg;
endmodule

[rtl/core/lslf_div.sv]
// Restoring divider: floor(num * 2^16 / den), saturated to a limit,
// one quotient bit per cycle. Depends on lslf_pkg for widths.
module lslf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lslf_pkg::NUM_W-1:0]  num,
    input  logic [lslf_pkg::DEN_W-1:0]  den,
    input  logic [lslf_pkg::QW-1:0]     limit,
    output logic [lslf_pkg::QW-1:0]     quot,
    output logic                        done
);
    localparam int NUM_W = lslf_pkg::NUM_W;
    localparam int DEN_W = lslf_pkg::DEN_W;
    localparam int QW    = lslf_pkg::QW;
    localparam int SH_W  = NUM_W + lslf_pkg::QF;
    localparam int CW    = $clog2(SH_W);

    logic [SH_W-1:0]  num_reg;
    logic [DEN_W-1:0] den_reg, rem_reg;
    logic [QW:0]      q_reg;
    logic [QW-1:0]    lim_reg;
    logic             sat_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic             last, ge;
    logic [DEN_W-1:0] rem_sh, rem_n;
    logic [QW:0]      q_n;

    assign last   = (cnt_reg == CW'(SH_W - 1));
    assign rem_sh = {rem_reg[DEN_W-2:0], num_reg[SH_W-1]};
    assign ge     = (rem_sh >= den_reg);
    assign rem_n  = ge ? (rem_sh - den_reg) : rem_sh;
    assign q_n    = {q_reg[QW-1:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {num, {lslf_pkg::QF{1'b0}}};
            den_reg <= den;
            lim_reg <= limit;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_n;
            // hold the quotient once it passes the limit
            if (!sat_reg) begin
                q_reg <= q_n;
                if (q_n > {1'b0, lim_reg}) begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = sat_reg ? lim_reg : q_reg[QW-1:0];
    assign done = done_reg;
endmodule

[rtl/core/lslf_ctrl.sv]
// Fit sequencer: takes pairs, steps through the fit program, hands off
// the result. Depends on lslf_pkg for op codes and link types.
module lslf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last_point,
    output logic                s_ready,
    input  lslf_pkg::status_t   status,
    output lslf_pkg::cmd_t      cmd
);
    typedef enum logic [1:0] {ST_ACC, ST_ISSUE, ST_WAIT, ST_DONE} state_t;

    state_t                       state_reg, state_next;
    logic [lslf_pkg::STEPW-1:0]   step_reg, step_next;
    lslf_pkg::op_t                op_cur;

    assign op_cur = lslf_pkg::prog(step_reg);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_ACC: begin
                if (s_valid && s_last_point) begin
                    state_next = ST_ISSUE;
                    step_next  = '0;
                end
            end
            ST_ISSUE: begin
                priority if (op_cur == lslf_pkg::OP_END) begin
                    state_next = ST_DONE;
                end else if (op_cur == lslf_pkg::OP_CHECK) begin
                    if (status.degen) begin
                        state_next = ST_DONE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (status.done) begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready   = (state_reg == ST_ACC);
    assign cmd.acc   = (state_reg == ST_ACC) && s_valid;
    assign cmd.start = (state_reg == ST_ISSUE) && (op_cur != lslf_pkg::OP_END) &&
                       (op_cur != lslf_pkg::OP_CHECK);
    assign cmd.op    = op_cur;
    assign cmd.load  = (state_reg == ST_DONE) && status.out_free;
endmodule

[rtl/core/lslf_datapath.sv]
// Running sums, fit registers, shared multiplier and divider, result
// register. Depends on lslf_pkg, lslf_mul and lslf_div.
module lslf_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  lslf_pkg::cmd_t      cmd,
    output lslf_pkg::status_t   status,
    input  logic signed [15:0]  x_sample,
    input  logic signed [15:0]  y_sample,
    input  logic                m_ready,
    output logic                m_valid,
    output logic signed [31:0]  m_slope,
    output logic signed [31:0]  m_intercept,
    output logic [16:0]         m_r_squared,
    output logic [31:0]         m_residual_var,
    output logic [31:0]         m_slope_var,
    output logic [31:0]         m_intercept_var,
    output logic [12:0]         m_point_total,
    output logic                m_degenerate
);
    localparam int XW    = lslf_pkg::XW;
    localparam int SUMW  = lslf_pkg::SUMW;
    localparam int SQW   = lslf_pkg::SQW;
    localparam int CNTW  = lslf_pkg::CNTW;
    localparam int TW    = lslf_pkg::TW;
    localparam int DW    = lslf_pkg::DW;
    localparam int MA_W  = lslf_pkg::MA_W;
    localparam int MB_W  = lslf_pkg::MB_W;
    localparam int MP_W  = lslf_pkg::MP_W;
    localparam int PRW   = lslf_pkg::PRW;
    localparam int NUM_W = lslf_pkg::NUM_W;
    localparam int DEN_W = lslf_pkg::DEN_W;
    localparam int QW    = lslf_pkg::QW;
    localparam int PW    = 2 * XW;

    // running sums, two's complement
    logic [SUMW-1:0]  sum_x_reg, sum_y_reg;
    logic [SQW-1:0]   sum_xx_reg, sum_xy_reg, sum_yy_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic signed [PW-1:0] xx, xy, yy;

    // fit registers
    lslf_pkg::op_t    op_reg;
    logic [TW-1:0]    t1_reg, nb_mag_reg;
    logic [DW-1:0]    dx_reg, dy_reg, dxy_mag_reg;
    logic             dxy_neg_reg, nb_neg_reg;
    logic [MA_W-1:0]  sq_reg, dxdy_reg, e_reg, dx2_reg;
    logic [PRW-1:0]   prod_reg;
    logic [NUM_W-1:0] num5_reg;
    logic [QW-1:0]    slope_reg, icpt_reg, res_reg, svar_reg, ivar_reg;
    logic [16:0]      r2_reg;

    // result register
    logic             m_valid_reg;
    logic [QW-1:0]    o_slope_reg, o_icpt_reg, o_res_reg, o_svar_reg, o_ivar_reg;
    logic [16:0]      o_r2_reg;
    logic [CNTW-1:0]  o_cnt_reg;
    logic             o_degen_reg;

    logic [SUMW-1:0]  sx_mag, sy_mag;
    logic [SQW-1:0]   sxy_mag;
    logic             sx_neg, sy_neg, sxy_neg;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [MP_W-1:0]  mul_p;
    logic             mul_done, mul_start, div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [QW-1:0]    div_lim, div_q;
    logic             p_neg;
    logic [TW-1:0]    p_lo, p_s, diff, diff_mag;
    logic             degen;

    assign xx = x_sample * x_sample;
    assign xy = x_sample * y_sample;
    assign yy = y_sample * y_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
            sum_yy_reg <= '0;
            cnt_reg    <= '0;
        end else if (cmd.load) begin
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
            sum_yy_reg <= '0;
            cnt_reg    <= '0;
        end else if (cmd.acc && (cnt_reg < CNTW'(lslf_pkg::MAX_POINTS))) begin
            // drop pairs beyond the set limit
            sum_x_reg  <= sum_x_reg + {{(SUMW-XW){x_sample[XW-1]}}, x_sample};
            sum_y_reg  <= sum_y_reg + {{(SUMW-XW){y_sample[XW-1]}}, y_sample};
            sum_xx_reg <= sum_xx_reg + {{(SQW-PW){1'b0}}, xx[PW-1:0]};
            sum_xy_reg <= sum_xy_reg + {{(SQW-PW){xy[PW-1]}}, xy[PW-1:0]};
            sum_yy_reg <= sum_yy_reg + {{(SQW-PW){1'b0}}, yy[PW-1:0]};
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    assign sx_neg  = sum_x_reg[SUMW-1];
    assign sy_neg  = sum_y_reg[SUMW-1];
    assign sxy_neg = sum_xy_reg[SQW-1];
    assign sx_mag  = sx_neg ? (~sum_x_reg + 1'b1) : sum_x_reg;
    assign sy_mag  = sy_neg ? (~sum_y_reg + 1'b1) : sum_y_reg;
    assign sxy_mag = sxy_neg ? (~sum_xy_reg + 1'b1) : sum_xy_reg;

    assign mul_start = cmd.start && !lslf_pkg::is_div(cmd.op);
    assign div_start = cmd.start && lslf_pkg::is_div(cmd.op);

    // multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            lslf_pkg::OP_MUL_N_SXX: begin
                mul_a = MA_W'(cnt_reg);
                mul_b = MB_W'(sum_xx_reg);
            end
            lslf_pkg::OP_MUL_SX_SX: begin
                mul_a = MA_W'(sx_mag);
                mul_b = MB_W'(sx_mag);
            end
            lslf_pkg::OP_MUL_N_SYY: begin
                mul_a = MA_W'(cnt_reg);
                mul_b = MB_W'(sum_yy_reg);
            end
            lslf_pkg::OP_MUL_SY_SY: begin
                mul_a = MA_W'(sy_mag);
                mul_b = MB_W'(sy_mag);
            end
            lslf_pkg::OP_MUL_N_SXY: begin
                mul_a = MA_W'(cnt_reg);
                mul_b = MB_W'(sxy_mag);
            end
            lslf_pkg::OP_MUL_SX_SY: begin
                mul_a = MA_W'(sx_mag);
                mul_b = MB_W'(sy_mag);
            end
            lslf_pkg::OP_MUL_SY_SXX: begin
                mul_a = MA_W'(sy_mag);
                mul_b = MB_W'(sum_xx_reg);
            end
            lslf_pkg::OP_MUL_SX_SXY: begin
                mul_a = MA_W'(sx_mag);
                mul_b = MB_W'(sxy_mag);
            end
            lslf_pkg::OP_MUL_DXY_DXY: begin
                mul_a = MA_W'(dxy_mag_reg);
                mul_b = MB_W'(dxy_mag_reg);
            end
            lslf_pkg::OP_MUL_DX_DY: begin
                mul_a = MA_W'(dx_reg);
                mul_b = MB_W'(dy_reg);
            end
            lslf_pkg::OP_MUL_DX_N: begin
                mul_a = MA_W'(dx_reg);
                mul_b = MB_W'(cnt_reg);
            end
            lslf_pkg::OP_MUL_T_N: begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = MB_W'(cnt_reg);
            end
            lslf_pkg::OP_MUL_DX_DX: begin
                mul_a = MA_W'(dx_reg);
                mul_b = MB_W'(dx_reg);
            end
            lslf_pkg::OP_MUL_DX2_N: begin
                mul_a = dx2_reg;
                mul_b = MB_W'(cnt_reg);
            end
            lslf_pkg::OP_MUL_E_SXX: begin
                mul_a = e_reg;
                mul_b = MB_W'(sum_xx_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operands
    always_comb begin
        div_num = '0;
        div_den = '0;
        div_lim = lslf_pkg::LIM_U;
        unique case (cmd.op)
            lslf_pkg::OP_DIV_SLOPE: begin
                div_num = NUM_W'(dxy_mag_reg);
                div_den = DEN_W'(dx_reg);
                div_lim = dxy_neg_reg ? lslf_pkg::LIM_NEG : lslf_pkg::LIM_POS;
            end
            lslf_pkg::OP_DIV_ICPT: begin
                div_num = NUM_W'(nb_mag_reg);
                div_den = DEN_W'(dx_reg) << lslf_pkg::FRAC_BITS;
                div_lim = nb_neg_reg ? lslf_pkg::LIM_NEG : lslf_pkg::LIM_POS;
            end
            lslf_pkg::OP_DIV_R2: begin
                div_num = NUM_W'(sq_reg);
                div_den = DEN_W'(dxdy_reg);
                div_lim = lslf_pkg::LIM_R2;
            end
            lslf_pkg::OP_DIV_RES: begin
                div_num = NUM_W'(e_reg);
                div_den = DEN_W'(prod_reg) << (2 * lslf_pkg::FRAC_BITS);
            end
            lslf_pkg::OP_DIV_SVAR: begin
                div_num = NUM_W'(e_reg);
                div_den = DEN_W'(dx2_reg);
            end
            lslf_pkg::OP_DIV_IVAR: begin
                div_num = num5_reg;
                div_den = DEN_W'(prod_reg) << (2 * lslf_pkg::FRAC_BITS);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    lslf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .p       (mul_p),
        .done    (mul_done)
    );

    lslf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .limit   (div_lim),
        .quot    (div_q),
        .done    (div_done)
    );

    // signed product and difference against the scratch term
    always_comb begin
        unique case (op_reg)
            lslf_pkg::OP_MUL_N_SXY:  p_neg = sxy_neg;
            lslf_pkg::OP_MUL_SX_SY:  p_neg = sx_neg ^ sy_neg;
            lslf_pkg::OP_MUL_SY_SXX: p_neg = sy_neg;
            lslf_pkg::OP_MUL_SX_SXY: p_neg = sx_neg ^ sxy_neg;
            default:                 p_neg = 1'b0;
        endcase
    end

    assign p_lo     = mul_p[TW-1:0];
    assign p_s      = p_neg ? (~p_lo + 1'b1) : p_lo;
    assign diff     = t1_reg - p_s;
    assign diff_mag = diff[TW-1] ? (~diff + 1'b1) : diff;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg <= cmd.op;
        end
        if (mul_done) begin
            unique case (op_reg)
                lslf_pkg::OP_MUL_N_SXX,
                lslf_pkg::OP_MUL_N_SYY,
                lslf_pkg::OP_MUL_N_SXY,
                lslf_pkg::OP_MUL_SY_SXX: t1_reg <= p_s;
                lslf_pkg::OP_MUL_SX_SX:  dx_reg <= diff[DW-1:0];
                lslf_pkg::OP_MUL_SY_SY:  dy_reg <= diff[DW-1:0];
                lslf_pkg::OP_MUL_SX_SY: begin
                    dxy_neg_reg <= diff[TW-1];
                    dxy_mag_reg <= diff_mag[DW-1:0];
                end
                lslf_pkg::OP_MUL_SX_SXY: begin
                    nb_neg_reg <= diff[TW-1];
                    nb_mag_reg <= diff_mag;
                end
                lslf_pkg::OP_MUL_DXY_DXY: sq_reg <= mul_p[MA_W-1:0];
                lslf_pkg::OP_MUL_DX_DY: begin
                    dxdy_reg <= mul_p[MA_W-1:0];
                    e_reg    <= mul_p[MA_W-1:0] - sq_reg;
                end
                lslf_pkg::OP_MUL_DX_N,
                lslf_pkg::OP_MUL_T_N,
                lslf_pkg::OP_MUL_DX2_N:  prod_reg <= mul_p[PRW-1:0];
                lslf_pkg::OP_MUL_DX_DX:  dx2_reg  <= mul_p[MA_W-1:0];
                lslf_pkg::OP_MUL_E_SXX:  num5_reg <= mul_p[NUM_W-1:0];
                default: ;
            endcase
        end
        if (div_done) begin
            unique case (op_reg)
                lslf_pkg::OP_DIV_SLOPE:
                    slope_reg <= dxy_neg_reg ? (~div_q + 1'b1) : div_q;
                lslf_pkg::OP_DIV_ICPT:
                    icpt_reg <= nb_neg_reg ? (~div_q + 1'b1) : div_q;
                lslf_pkg::OP_DIV_R2:   r2_reg   <= div_q[16:0];
                lslf_pkg::OP_DIV_RES:  res_reg  <= div_q;
                lslf_pkg::OP_DIV_SVAR: svar_reg <= div_q;
                lslf_pkg::OP_DIV_IVAR: ivar_reg <= div_q;
                default: ;
            endcase
        end
    end

    assign degen = (cnt_reg == '0) || (dx_reg == '0) || (dy_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            o_slope_reg <= degen ? '0 : slope_reg;
            o_icpt_reg  <= degen ? '0 : icpt_reg;
            o_r2_reg    <= degen ? '0 : r2_reg;
            o_res_reg   <= degen ? '0 : res_reg;
            o_svar_reg  <= degen ? '0 : svar_reg;
            o_ivar_reg  <= degen ? '0 : ivar_reg;
            o_cnt_reg   <= cnt_reg;
            o_degen_reg <= degen;
        end
    end

    assign status.done     = mul_done || div_done;
    assign status.degen    = degen;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_slope         = o_slope_reg;
    assign m_intercept     = o_icpt_reg;
    assign m_r_squared     = o_r2_reg;
    assign m_residual_var  = o_res_reg;
    assign m_slope_var     = o_svar_reg;
    assign m_intercept_var = o_ivar_reg;
    assign m_point_total   = o_cnt_reg;
    assign m_degenerate    = o_degen_reg;
endmodule

[rtl/core/lslf_checker.sv]
// Port-level checks for the line fit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lslf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_slope,
    input logic signed [31:0] m_intercept,
    input logic [16:0]        m_r_squared,
    input logic [31:0]        m_residual_var,
    input logic [12:0]        m_point_total,
    input logic               m_degenerate
);
    `LSLF_ASSERT(a_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `LSLF_ASSERT(a_data_hold, aclk, aresetn,
        m_valid && !m_ready |=> $stable(m_slope) && $stable(m_residual_var))
    `LSLF_ASSERT_MSG(a_degen_zero, aclk, aresetn,
        m_valid && m_degenerate |-> m_slope == 0 && m_intercept == 0 && m_r_squared == 0,
        "degenerate result carries nonzero fit")
    `LSLF_ASSERT_MSG(a_r2_range, aclk, aresetn,
        m_valid |-> m_r_squared <= 17'd65536, "r squared above one")
    `LSLF_ASSERT_MSG(a_fit_points, aclk, aresetn,
        m_valid && !m_degenerate |-> m_point_total >= 13'd2,
        "fit reported over fewer than two pairs")
endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (.*);
